@@ hw/rtl/ahc_pkg.sv @@
// Package: shared types and constants of the adjacent hit clusterer.
`default_nettype none

package ahc_pkg;

  // Field widths
  localparam int unsigned ChanW  = 6;
  localparam int unsigned SizeW  = 7;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 7;

  // Default number of channels
  localparam int unsigned AhcChannels = 64;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_CLUSTER_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_WIDTH    = 2'd1;

  // Cluster mode codes (code three acts as contiguous)
  localparam logic [ModeW-1:0] MODE_NONE       = 2'd0;
  localparam logic [ModeW-1:0] MODE_CONTIGUOUS = 2'd1;
  localparam logic [ModeW-1:0] MODE_ISOLATED   = 2'd2;

  // Input action codes
  localparam logic ACT_HIT = 1'b0;
  localparam logic ACT_END = 1'b1;

  // Reset values of the configuration registers
  localparam logic [ModeW-1:0] MODE_RESET      = MODE_CONTIGUOUS;
  localparam logic [SizeW-1:0] MAX_WIDTH_RESET = 7'd2;

  typedef struct packed {
    logic             action;
    logic [ChanW-1:0] channel;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0] first_channel;
    logic [SizeW-1:0] cluster_size;
    logic             last_of_run;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // take the input transaction
    logic advance;  // output transaction taken, step to next result
  } ahc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_result;  // the presented input produces at least one result
    logic more;        // further split results remain after the current one
  } ahc_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/ahc_ctrl.sv @@
// Controller: sequences input acceptance and result delivery.
`default_nettype none

module ahc_ctrl
  import ahc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  input  wire ahc_sts_t sts_i,
  output ahc_cmd_t      cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e state_q;

  // Commands from current state and handshakes
  always_comb begin
    cmd_o.accept  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.advance = (state_q == ST_EMIT) && !out_stall_i;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && sts_i.has_result) state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_stall_i && !sts_i.more) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ahc_datapath.sv @@
// Datapath: configuration, open cluster state and the result register.
`default_nettype none

module ahc_datapath
  import ahc_pkg::*;
#(
  parameter int unsigned Channels = AhcChannels
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire in_item_t            in_data_i,
  input  wire ahc_cmd_t            cmd_i,
  output ahc_sts_t                 sts_o,
  output out_item_t                out_data_o
);

  // Configuration
  logic [ModeW-1:0] mode_q;
  logic [SizeW-1:0] max_width_q;

  // Open cluster
  logic             open_q, open_d;
  logic [ChanW-1:0] first_q, first_d;
  logic [ChanW-1:0] prev_q, prev_d;

  // Result register and split counter
  logic [ChanW-1:0] out_first_q, out_first_d;
  logic [SizeW-1:0] out_size_q, out_size_d;
  logic             out_last_q, out_last_d;
  logic [SizeW-1:0] rem_q, rem_d;

  logic             is_end, in_range, join_hit, single_hit, close_now, split;
  logic [SizeW-1:0] size_w;
  logic [SizeW-1:0] prev_inc;

  // Decode of the presented input against the open cluster
  always_comb begin
    is_end     = (in_data_i.action == ACT_END);
    in_range   = ({1'b0, in_data_i.channel} < SizeW'(Channels));
    prev_inc   = {1'b0, prev_q} + SizeW'(1);
    join_hit   = open_q && ({1'b0, in_data_i.channel} == prev_inc);
    single_hit = !is_end && in_range && (mode_q == MODE_NONE);
    close_now  = is_end ? open_q
                        : (in_range && (mode_q != MODE_NONE) && open_q && !join_hit);
    size_w     = {1'b0, ChanW'(prev_q - first_q)} + SizeW'(1);
    split      = (mode_q == MODE_ISOLATED) && (size_w > max_width_q);
  end

  assign sts_o.has_result = single_hit || close_now;
  assign sts_o.more       = (rem_q != '0);

  // Next values of cluster state and result register
  always_comb begin
    open_d      = open_q;
    first_d     = first_q;
    prev_d      = prev_q;
    out_first_d = out_first_q;
    out_size_d  = out_size_q;
    out_last_d  = out_last_q;
    rem_d       = rem_q;
    if (cmd_i.accept) begin
      if (single_hit) begin
        out_first_d = in_data_i.channel;
        out_size_d  = SizeW'(1);
        out_last_d  = 1'b1;
        rem_d       = '0;
      end else if (close_now) begin
        out_first_d = first_q;
        if (split) begin
          out_size_d = SizeW'(1);
          out_last_d = (size_w == SizeW'(1));
          rem_d      = size_w - SizeW'(1);
        end else begin
          out_size_d = size_w;
          out_last_d = 1'b1;
          rem_d      = '0;
        end
      end
      // Cluster bookkeeping
      if (is_end) begin
        open_d = 1'b0;
      end else if (in_range && (mode_q != MODE_NONE)) begin
        if (join_hit) begin
          prev_d = in_data_i.channel;
        end else begin
          open_d  = 1'b1;
          first_d = in_data_i.channel;
          prev_d  = in_data_i.channel;
        end
      end
    end else if (cmd_i.advance && (rem_q != '0)) begin
      // Next single-hit result of a split cluster
      out_first_d = out_first_q + ChanW'(1);
      out_size_d  = SizeW'(1);
      out_last_d  = (rem_q == SizeW'(1));
      rem_d       = rem_q - SizeW'(1);
    end
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_RESET;
      max_width_q <= MAX_WIDTH_RESET;
      open_q      <= 1'b0;
      first_q     <= '0;
      prev_q      <= '0;
      rem_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_CLUSTER_MODE: mode_q      <= cfg_data_i[ModeW-1:0];
          CFG_MAX_WIDTH:    max_width_q <= cfg_data_i[SizeW-1:0];
          default:          ;
        endcase
      end
      open_q  <= open_d;
      first_q <= first_d;
      prev_q  <= prev_d;
      rem_q   <= rem_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_first_q <= out_first_d;
    out_size_q  <= out_size_d;
    out_last_q  <= out_last_d;
  end

  assign out_data_o.first_channel = out_first_q;
  assign out_data_o.cluster_size  = out_size_q;
  assign out_data_o.last_of_run   = out_last_q;

endmodule

`default_nettype wire

@@ hw/rtl/adjacent_hit_clusterer.sv @@
// Top level: adjacent hit clusterer, controller plus datapath.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------
//  input   | in        | in_valid_i / in_stall_o  | in_data_i  (in_item_t)
//  output  | out       | out_valid_o / out_stall_i| out_data_o (out_item_t)
//  config  | in        | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// An input transaction without results is just accepted; one that yields
// results is accepted, then its results go out in turn. A split cluster
// yields one result per cycle while out_stall_i is low, set by the split
// counter. Input is stalled while results are pending. Reset is
// asynchronous, leaves no cluster open, mode contiguous, max width two.
`default_nettype none

module adjacent_hit_clusterer
  import ahc_pkg::*;
#(
  parameter int unsigned Channels = AhcChannels
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_item_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  ahc_cmd_t cmd;
  ahc_sts_t sts;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  ahc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ahc_datapath #(
    .Channels (Channels)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Testbench: self-checking test of the adjacent hit clusterer, driven through all modes.
`timescale 1ns / 1ps

module tb_top;
  import ahc_pkg::*;

  localparam int NumChannels = AhcChannels;
  localparam int CycleLimit  = 200000;
  // Mode code three is not named in the package; it acts as contiguous
  localparam logic [ModeW-1:0] MODE_SPARE = 2'd3;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  adjacent_hit_clusterer #(
    .Channels(NumChannels)
  ) uut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Shared run state
  int fail_count   = 0;
  int cycle_count  = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_len     = 0;
  int hold_req     = 0;

  // Shadow of the clusterer: registers, open cluster and pending clusters
  logic [ModeW-1:0]  mode_reg;
  logic [SizeW-1:0]  max_width_reg;
  logic              clu_open;
  logic [ChanW-1:0]  clu_first;
  logic [ChanW-1:0]  clu_prev;
  out_item_t         expected_clusters[$];

  function automatic void queue_cluster(logic [ChanW-1:0] first_ch, logic [SizeW-1:0] clu_size);
    out_item_t c;
    c.first_channel = first_ch;
    c.cluster_size  = clu_size;
    c.last_of_run   = 1'b0;
    expected_clusters.push_back(c);
  endfunction

  // Close the open cluster; wide ones split into single hits in isolated mode
  function automatic void close_open_cluster();
    logic [SizeW-1:0] clu_size;
    clu_size = {1'b0, clu_prev - clu_first} + 7'd1;
    if (mode_reg == MODE_ISOLATED && clu_size > max_width_reg) begin
      for (int i = 0; i < int'(clu_size); i++) queue_cluster(clu_first + ChanW'(i), 7'd1);
    end else begin
      queue_cluster(clu_first, clu_size);
    end
    clu_open = 1'b0;
  endfunction

  function automatic void predict_clusters(in_item_t item);
    int        n_before;
    out_item_t tail;
    n_before = expected_clusters.size();
    if (item.action == ACT_END) begin
      if (clu_open) close_open_cluster();
    end else if (int'(item.channel) < NumChannels) begin
      if (mode_reg == MODE_NONE) begin
        // open cluster stays as it is
        queue_cluster(item.channel, 7'd1);
      end else if (clu_open && int'(item.channel) == int'(clu_prev) + 1) begin
        clu_prev = item.channel;
      end else begin
        if (clu_open) close_open_cluster();
        clu_open  = 1'b1;
        clu_first = item.channel;
        clu_prev  = item.channel;
      end
    end
    // flag the final cluster of this transaction
    if (expected_clusters.size() > n_before) begin
      tail = expected_clusters.pop_back();
      tail.last_of_run = 1'b1;
      expected_clusters.push_back(tail);
    end
  endfunction

  // Track config writes and input transactions, check output transactions
  always @(posedge clk_i) begin : track_and_check
    out_item_t want;
    if (!rst_ni) begin
      mode_reg      = MODE_RESET;
      max_width_reg = MAX_WIDTH_RESET;
      clu_open      = 1'b0;
      clu_first     = '0;
      clu_prev      = '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_CLUSTER_MODE: mode_reg = cfg_data_i[ModeW-1:0];
          CFG_MAX_WIDTH:    max_width_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) predict_clusters(in_data_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_clusters.size() == 0) begin
          $error("unexpected cluster: first_channel %0d size %0d",
                 out_data_o.first_channel, out_data_o.cluster_size);
          fail_count++;
        end else begin
          want = expected_clusters.pop_front();
          if (out_data_o.first_channel !== want.first_channel) begin
            $error("first_channel: expected %0d, actual %0d",
                   want.first_channel, out_data_o.first_channel);
            fail_count++;
          end
          if (out_data_o.cluster_size !== want.cluster_size) begin
            $error("cluster_size: expected %0d, actual %0d",
                   want.cluster_size, out_data_o.cluster_size);
            fail_count++;
          end
          if (out_data_o.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d",
                   want.last_of_run, out_data_o.last_of_run);
            fail_count++;
          end
        end
      end
    end
  end

  // Receiver: random stall, or a long hold-off when requested
  always @(posedge clk_i) begin : receiver
    int hold_ack;
    int hold_left;
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one input transaction, with random idle cycles ahead of it
  task automatic send_item(in_item_t item);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_hit(int ch);
    in_item_t item;
    item.action  = ACT_HIT;
    item.channel = ChanW'(ch);
    send_item(item);
  endtask

  task automatic send_end();
    in_item_t item;
    item.action  = ACT_END;
    item.channel = ChanW'($urandom_range(0, NumChannels - 1));
    send_item(item);
  endtask

  // Stop offering and wait until every expected cluster has come out
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (expected_clusters.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Joining, gaps, repeated and descending hits, empty group end, top channel
  task automatic test_contiguous_runs();
    send_hit(0);
    send_hit(1);
    send_hit(2);
    send_hit(5);
    send_hit(5);
    send_hit(4);
    send_end();
    send_end();
    send_hit(63);
    send_end();
    wait_drain();
  endtask

  // Splitting of wide clusters, including max width zero
  task automatic test_isolated_split();
    write_register(CFG_CLUSTER_MODE, CfgDataW'(MODE_ISOLATED));
    send_hit(10);
    send_hit(11);
    send_hit(12);
    send_end();
    send_hit(20);
    send_hit(21);
    send_end();
    wait_drain();
    write_register(CFG_MAX_WIDTH, 7'd0);
    send_hit(40);
    send_end();
    wait_drain();
  endtask

  // Mode none with a cluster left open, then mode code three
  task automatic test_mode_none();
    write_register(CFG_CLUSTER_MODE, CfgDataW'(MODE_CONTIGUOUS));
    send_hit(30);
    wait_drain();
    write_register(CFG_CLUSTER_MODE, CfgDataW'(MODE_NONE));
    send_hit(31);
    send_hit(63);
    send_end();
    wait_drain();
    write_register(CFG_CLUSTER_MODE, CfgDataW'(MODE_SPARE));
    send_hit(1);
    send_hit(2);
    send_end();
    wait_drain();
  endtask

  // Split decision uses the registers in force when the cluster closes
  task automatic test_config_at_close();
    write_register(CFG_CLUSTER_MODE, CfgDataW'(MODE_CONTIGUOUS));
    send_hit(50);
    send_hit(51);
    send_hit(52);
    wait_drain();
    write_register(CFG_CLUSTER_MODE, CfgDataW'(MODE_ISOLATED));
    write_register(CFG_MAX_WIDTH, 7'd1);
    send_end();
    wait_drain();
  endtask

  // Every channel in one cluster: one end item yields 64 single-hit clusters
  task automatic test_full_span();
    write_register(CFG_CLUSTER_MODE, CfgDataW'(MODE_ISOLATED));
    write_register(CFG_MAX_WIDTH, 7'd63);
    snd_idle_pct = 10;
    rcv_idle_pct = 30;
    for (int ch = 0; ch < NumChannels; ch++) send_hit(ch);
    send_end();
    wait_drain();
  endtask

  // Receiver holds off long enough for the input side to back up
  task automatic test_output_backpressure();
    int ch;
    write_register(CFG_CLUSTER_MODE, CfgDataW'(MODE_NONE));
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_len = 200;
    hold_req++;
    ch = 0;
    for (int k = 0; k < 24; k++) begin
      send_hit(ch);
      ch = (ch + $urandom_range(1, 3)) % NumChannels;
    end
    wait_drain();
  endtask

  // One ascending group with random runs, plus some noise and missing ends
  task automatic send_random_group(inout int sent);
    int ch;
    int steps;
    int r;
    ch = $urandom_range(0, 40);
    steps = $urandom_range(1, 12);
    for (int k = 0; k < steps && ch < NumChannels; k++) begin
      send_hit(ch);
      sent++;
      r = $urandom_range(0, 99);
      if (r < 55) ch = ch + 1;
      else if (r < 85) ch = ch + $urandom_range(2, 6);
      else if (r < 92) ch = ch;
      else ch = $urandom_range(0, NumChannels - 1);
    end
    if ($urandom_range(0, 9) != 0) begin
      send_end();
      sent++;
    end
  endtask

  task automatic random_config();
    int r;
    logic [CfgDataW-1:0] width;
    r = $urandom_range(0, 9);
    if (r < 2) write_register(CFG_CLUSTER_MODE, CfgDataW'(MODE_NONE));
    else if (r < 5) write_register(CFG_CLUSTER_MODE, CfgDataW'(MODE_CONTIGUOUS));
    else if (r < 9) write_register(CFG_CLUSTER_MODE, CfgDataW'(MODE_ISOLATED));
    else write_register(CFG_CLUSTER_MODE, CfgDataW'(MODE_SPARE));
    case ($urandom_range(0, 5))
      0:       width = 7'd0;
      1:       width = 7'd1;
      2:       width = 7'd64;
      3:       width = 7'd127;
      default: width = CfgDataW'($urandom_range(1, 8));
    endcase
    write_register(CFG_MAX_WIDTH, width);
  endtask

  // Random groups under two register settings with the given idle rates
  task automatic test_random_traffic(int snd_pct, int rcv_pct, int n_items);
    int sent;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    for (int setting = 0; setting < 2; setting++) begin
      random_config();
      sent = 0;
      while (sent < n_items / 2) send_random_group(sent);
      wait_drain();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_contiguous_runs();
    test_isolated_split();
    test_mode_none();
    test_config_at_close();
    test_full_span();
    test_output_backpressure();
    test_random_traffic(24, 61, 24);
    test_random_traffic(61, 24, 24);
    test_random_traffic(0, 0, 24);

    wait_drain();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0 && expected_clusters.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ adjacent_hit_clusterer.f @@
hw/rtl/ahc_pkg.sv
hw/rtl/ahc_ctrl.sv
hw/rtl/ahc_datapath.sv
hw/rtl/adjacent_hit_clusterer.sv
verif/tb_top.sv
